/* rtl/rf_command_frame_receiver_core_defines.svh */
// assertion macros for the rf command frame receiver
// included by the top level only, no other dependencies
`ifndef RF_COMMAND_FRAME_RECEIVER_CORE_DEFINES_SVH
`define RF_COMMAND_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RFCFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RFCFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rfcfr_pkg.sv */
// shared types and constants for the rf command frame receiver
// no dependencies
`default_nettype none

package rfcfr_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] SyncByte    = 8'hAA;
  localparam logic [ByteW-1:0] HeaderLast  = 8'd3;   // index of the length byte
  localparam logic [ByteW-1:0] HdrCheckPos = 8'd1;
  localparam logic [ByteW-1:0] HdrCmdPos   = 8'd2;
  localparam logic [ByteW-1:0] MaxData     = 8'd16;
  localparam logic [ByteW-1:0] CmdAction   = 8'd1;
  localparam logic [ByteW-1:0] ActionLen   = 8'd2;

  // configuration register indexes
  localparam logic CfgEventCount = 1'b0;
  localparam logic CfgPowerCount = 1'b1;

  // action kinds
  localparam logic ActEvent = 1'b0;
  localparam logic ActPower = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] event_count;
    logic [ByteW-1:0] power_count;
  } cfg_t;

  // frame that passed checksum and command checks
  typedef struct packed {
    logic [ByteW-1:0] data0;
    logic [ByteW-1:0] data1;
  } hit_t;

endpackage

`default_nettype wire

/* rtl/rfcfr_rx_if.sv */
// receive byte channel, valid/ready handshake
// no dependencies
`default_nettype none

interface rfcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/rfcfr_action_if.sv */
// action result channel, valid/ready handshake
// no dependencies
`default_nettype none

interface rfcfr_action_if;
  logic       valid;
  logic       ready;
  logic       action_kind;
  logic [7:0] action_index;
  logic [7:0] action_value;

  modport source (output valid, output action_kind, output action_index,
                  output action_value, input ready);
  modport sink (input valid, input action_kind, input action_index,
                input action_value, output ready);
endinterface

`default_nettype wire

/* rtl/rfcfr_parser.sv */
// frame parser: sync hunt, header, data and checksum phases
// depends on rfcfr_pkg and rfcfr_rx_if
`default_nettype none

module rfcfr_parser (
  input  wire               clk_i,
  input  wire               rst_ni,
  rfcfr_rx_if.sink          rx,
  input  wire               hit_take_i,
  output logic              hit_valid_o,
  output rfcfr_pkg::hit_t   hit_o
);
  import rfcfr_pkg::*;

  typedef enum logic [1:0] {
    PhHunt,
    PhHeader,
    PhData,
    PhCksum
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] d0_q, d0_d;
  logic [ByteW-1:0] d1_q, d1_d;
  logic             hit_valid_q, hit_valid_d;
  hit_t             hit_q, hit_d;

  logic             accept;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] cnt_inc;

  // the hit register doubles as a skid slot behind the action stage
  assign rx.ready    = !hit_valid_q || hit_take_i;
  assign accept      = rx.valid && rx.ready;
  assign b           = rx.rx_byte;
  assign cnt_inc     = cnt_q + 8'd1;
  assign hit_valid_o = hit_valid_q;
  assign hit_o       = hit_q;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    sum_d       = sum_q;
    hdr_ok_d    = hdr_ok_q;
    cmd_d       = cmd_q;
    d0_d        = d0_q;
    d1_d        = d1_q;
    hit_valid_d = hit_valid_q && !hit_take_i;
    hit_d       = hit_q;
    if (accept) begin
      case (phase_q)
        PhHunt: begin
          if (b == SyncByte) begin
            phase_d  = PhHeader;
            cnt_d    = '0;
            sum_d    = '0;
            hdr_ok_d = 1'b0;
          end
        end
        PhHeader: begin
          sum_d = sum_q + b;
          cnt_d = cnt_inc;
          if (cnt_q == HdrCheckPos) begin
            hdr_ok_d = (b == 8'd0) || (b == 8'd1);
          end
          if (cnt_q == HdrCmdPos) begin
            cmd_d = b;
          end
          if (cnt_q == HeaderLast) begin
            len_d = b;
            cnt_d = '0;
            // bytes of a rejected header are never taken as sync
            if (!hdr_ok_q || (b > MaxData)) begin
              phase_d = PhHunt;
            end else if (b == 8'd0) begin
              phase_d = PhCksum;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhData: begin
          sum_d = sum_q + b;
          cnt_d = cnt_inc;
          if (cnt_q == 8'd0) begin
            d0_d = b;
          end
          if (cnt_q == 8'd1) begin
            d1_d = b;
          end
          if (cnt_inc >= len_q) begin
            phase_d = PhCksum;
          end
        end
        PhCksum: begin
          phase_d = PhHunt;
          cnt_d   = '0;
          if ((b == sum_q) && (cmd_q == CmdAction) && (len_q == ActionLen)) begin
            hit_valid_d = 1'b1;
            hit_d.data0 = d0_q;
            hit_d.data1 = d1_q;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      cnt_q       <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      hdr_ok_q    <= 1'b0;
      cmd_q       <= '0;
      d0_q        <= '0;
      d1_q        <= '0;
      hit_valid_q <= 1'b0;
      hit_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      hdr_ok_q    <= hdr_ok_d;
      cmd_q       <= cmd_d;
      d0_q        <= d0_d;
      d1_q        <= d1_d;
      hit_valid_q <= hit_valid_d;
      hit_q       <= hit_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/rfcfr_action_dec.sv */
// action decode: maps data0 onto event or power range, output register
// depends on rfcfr_pkg and rfcfr_action_if
`default_nettype none

module rfcfr_action_dec (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  rfcfr_pkg::cfg_t   cfg_i,
  input  wire               hit_valid_i,
  input  rfcfr_pkg::hit_t   hit_i,
  output logic              hit_take_o,
  rfcfr_action_if.source    act
);
  import rfcfr_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic             kind_q;
  logic [ByteW-1:0] index_q;
  logic [ByteW-1:0] value_q;

  logic             in_event;
  logic [ByteW:0]   range_end;
  logic             in_range;
  logic             out_free;
  logic             load;

  // range end at 9 bits so it never wraps
  assign range_end  = {1'b0, cfg_i.event_count} + {1'b0, cfg_i.power_count};
  assign in_event   = hit_i.data0 < cfg_i.event_count;
  assign in_range   = {1'b0, hit_i.data0} < range_end;
  assign out_free   = !out_valid_q || act.ready;
  assign load       = hit_valid_i && in_range && out_free;
  // out-of-range hits drop without waiting on the output
  assign hit_take_o = hit_valid_i && (out_free || !in_range);
  assign out_valid_d = (out_valid_q && !act.ready) || load;

  assign act.valid        = out_valid_q;
  assign act.action_kind  = kind_q;
  assign act.action_index = index_q;
  assign act.action_value = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= in_event ? ActEvent : ActPower;
      index_q <= in_event ? hit_i.data0 : (hit_i.data0 - cfg_i.event_count);
      value_q <= hit_i.data1;
    end
  end

endmodule

`default_nettype wire

/* rtl/rf_command_frame_receiver_core.sv */
// Receiver for small rf command frames, fed one byte per transfer. It hunts for the
// sync byte 0xAA, takes a four-byte header, up to 16 data bytes and a checksum byte,
// and issues one action for a good command frame with a two-byte payload. A byte is
// taken every cycle while rx ready is high; an action passes the parser hit register
// and then the action output register after its checksum byte. rx ready drops only
// while one decoded frame waits behind a stalled action transfer.
// depends on rfcfr_pkg, rfcfr_rx_if, rfcfr_action_if, rfcfr_parser, rfcfr_action_dec
`default_nettype none
`include "rf_command_frame_receiver_core_defines.svh"

module rf_command_frame_receiver_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire               cfg_idx_i,
  input  wire [7:0]         cfg_wdata_i,
  rfcfr_rx_if.sink          rx_i,
  rfcfr_action_if.source    act_o
);
  import rfcfr_pkg::*;

  cfg_t cfg_q;
  logic hit_valid;
  hit_t hit;
  logic hit_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.event_count <= 8'd16;
      cfg_q.power_count <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEventCount: cfg_q.event_count <= cfg_wdata_i;
        CfgPowerCount: cfg_q.power_count <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rfcfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .hit_take_i  (hit_take),
    .hit_valid_o (hit_valid),
    .hit_o       (hit)
  );

  rfcfr_action_dec u_action_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .hit_valid_i (hit_valid),
    .hit_i       (hit),
    .hit_take_o  (hit_take),
    .act         (act_o)
  );

  `RFCFR_ASSERT_IMP(a_new_action_from_hit, clk_i, rst_ni, $rose(act_o.valid),
                    $past(hit_valid), "action without a decoded frame")
  `RFCFR_ASSERT_IMP(a_event_in_range, clk_i, rst_ni,
                    act_o.valid && (act_o.action_kind == ActEvent),
                    act_o.action_index < cfg_q.event_count, "event index out of range")
  `RFCFR_ASSERT_IMP(a_power_in_range, clk_i, rst_ni,
                    act_o.valid && (act_o.action_kind == ActPower),
                    act_o.action_index < cfg_q.power_count, "power index out of range")
  `RFCFR_ASSERT_NXT(a_hit_held, clk_i, rst_ni, hit_valid && !hit_take, hit_valid,
                    "pending frame lost under stall")

endmodule

`default_nettype wire
